[sv/crc_checked_record_sanitizer_macros.svh]
// Assertion macros shared by the sanitizer RTL.
`ifndef CRC_CHECKED_RECORD_SANITIZER_MACROS_SVH
`define CRC_CHECKED_RECORD_SANITIZER_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising clock edge outside reset.
`define CCRS_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("sanitizer check failed");

// Check that a condition in one cycle implies another in the next cycle.
`define CCRS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sanitizer sequence check failed");

`else

`define CCRS_ASSERT(label, prop)
`define CCRS_ASSERT_NEXT(label, ante, cons)

`endif

`endif

[sv/ccrs_pkg.sv]
// Types, constants and the CRC step shared by the record sanitizer.
`timescale 1ns / 1ps

package ccrs_pkg;

  localparam int NAME_BYTES_DEF    = 10;
  localparam int SCORE_ENTRIES_DEF = 8;
  localparam int RECORD_BASE       = 18;

  localparam logic [31:0] CRC_POLY     = 32'hedb88320;
  localparam logic [31:0] CRC_INIT     = 32'hffffffff;
  localparam logic [31:0] MAGIC_WORD   = 32'h31525351;
  localparam logic [7:0]  VERSION_CODE = 8'd1;
  localparam logic [7:0]  PRINT_LO     = 8'd32;
  localparam logic [7:0]  PRINT_HI     = 8'd127;

  // Byte offsets of the header fields, settings block and play count, and the magic length.
  localparam logic [7:0] OFS_VERSION    = 8'd4;
  localparam logic [7:0] OFS_BODY_LEN   = 8'd5;
  localparam logic [7:0] OFS_DIFFICULTY = 8'd6;
  localparam logic [7:0] OFS_SHAKE      = 8'd7;
  localparam logic [7:0] OFS_BRIGHTNESS = 8'd8;
  localparam logic [7:0] OFS_FPS_FLAG   = 8'd9;
  localparam logic [7:0] OFS_VSYNC      = 8'd10;
  localparam logic [7:0] OFS_STAGE_CAP  = 8'd11;
  localparam logic [7:0] OFS_CLEARS     = 8'd12;
  localparam logic [7:0] OFS_PLAY_LO    = 8'd14;
  localparam logic [7:0] OFS_PLAY_HI    = 8'd17;
  localparam logic [7:0] MAGIC_BYTES    = 8'd4;

  typedef enum logic [2:0] {
    VERDICT_OK         = 3'd0,
    VERDICT_SHORT      = 3'd1,
    VERDICT_BAD_MAGIC  = 3'd2,
    VERDICT_BAD_HEADER = 3'd3,
    VERDICT_BAD_CRC    = 3'd4
  } verdict_t;

  // One byte of reflected CRC-32, eight shift steps.
  function automatic logic [31:0] crc_byte_update(input logic [31:0] crc_in,
                                                  input logic [7:0]  data_in);
    logic [31:0] c;
    c = crc_in ^ {24'd0, data_in};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

[sv/crc_checked_record_sanitizer.sv]
// Byte-serial settings-and-score blob sanitizer with CRC-32 verdict.
`timescale 1ns / 1ps
// Timing: an accepted request lands in the input register, and its result is
//   loaded into the output register while that register is empty or being
//   drained.
// Throughput: one byte per cycle while the output keeps draining; the byte-wide CRC
//   update, field clamps and verdict compare sit between input and output registers.
// Reset: rst_n is synchronous, active low; it clears the valid flags and the
//   blob tracking state (offset 0, CRC all ones, header checks passing).

`include "crc_checked_record_sanitizer_macros.svh"

module crc_checked_record_sanitizer
  import ccrs_pkg::*;
#(
  parameter int NAME_BYTES    = NAME_BYTES_DEF,
  parameter int SCORE_ENTRIES = SCORE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // final_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] offset, [15:8] clean_value, [18:16] verdict
  output logic        out_tuser,  // is_field
  output logic        out_tlast   // done_res
);

  // Blob layout derived from the record geometry.
  localparam int RECORD_SPAN = NAME_BYTES + 8;
  localparam int CRC_SPAN    = RECORD_BASE + SCORE_ENTRIES * RECORD_SPAN;
  localparam int TOTAL_SPAN  = CRC_SPAN + 4;
  localparam int REC_W       = $clog2(RECORD_SPAN);

  localparam logic [7:0]       CRC_SPAN_B    = 8'(CRC_SPAN);
  localparam logic [7:0]       TOTAL_LAST_B  = 8'(TOTAL_SPAN - 1);
  localparam logic [7:0]       TOTAL_SPAN_B  = 8'(TOTAL_SPAN);
  localparam logic [7:0]       REC_BASE_B    = 8'(RECORD_BASE);
  localparam logic [REC_W-1:0] REC_LAST      = REC_W'(RECORD_SPAN - 1);
  localparam logic [REC_W-1:0] REC_STAGE     = REC_W'(NAME_BYTES);
  localparam logic [REC_W-1:0] REC_DIFF      = REC_W'(NAME_BYTES + 1);
  localparam logic [REC_W-1:0] REC_SCORE_END = REC_W'(NAME_BYTES + 6);

  // Input register.
  logic       s1_valid_r;
  logic [7:0] s1_data_r;
  logic       s1_last_r;

  // Blob tracking state.
  logic [7:0]       pos_r,       pos_nxt;
  logic [REC_W-1:0] rec_r,       rec_nxt;
  logic [31:0]      crc_r,       crc_nxt;
  logic [31:0]      stored_r,    stored_nxt;
  logic             magic_ok_r,  magic_ok_nxt;
  logic             header_ok_r, header_ok_nxt;

  // Output register.
  logic       out_valid_r;
  logic [7:0] out_offset_r;
  logic [7:0] out_clean_r;
  logic       out_field_r;
  logic       out_done_r;
  verdict_t   out_verdict_r;

  logic       adv;
  logic [7:0] v;
  logic [7:0] clean_val;
  logic       is_fld;
  logic       in_records;
  verdict_t   verdict_val;
  logic [7:0] crc_ofs;
  logic [7:0] magic_byte;

  // Advance the input register into the output register whenever the output
  // register is empty or being drained this cycle.
  assign adv       = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv;
  assign v         = s1_data_r;

  assign in_records = (pos_r >= REC_BASE_B) && (pos_r < CRC_SPAN_B);
  assign crc_ofs    = pos_r - CRC_SPAN_B;
  assign magic_byte = MAGIC_WORD[{pos_r[1:0], 3'b000} +: 8];

  // Header checks, CRC over the magic, header and body, and capture of the stored CRC.
  always_comb begin
    magic_ok_nxt  = magic_ok_r;
    header_ok_nxt = header_ok_r;
    crc_nxt       = crc_r;
    stored_nxt    = stored_r;
    if (pos_r < MAGIC_BYTES) begin
      if (v != magic_byte) magic_ok_nxt = 1'b0;
    end else if (pos_r == OFS_VERSION) begin
      if (v != VERSION_CODE) header_ok_nxt = 1'b0;
    end else if (pos_r == OFS_BODY_LEN) begin
      if (v != CRC_SPAN_B) header_ok_nxt = 1'b0;
    end
    if (pos_r < CRC_SPAN_B) begin
      crc_nxt = crc_byte_update(crc_r, v);
    end else if (pos_r < TOTAL_SPAN_B) begin
      stored_nxt[{crc_ofs[1:0], 3'b000} +: 8] = stored_r[{crc_ofs[1:0], 3'b000} +: 8] | v;
    end
  end

  // Verdict on the final byte, checked in priority order.
  always_comb begin
    verdict_val = VERDICT_OK;
    if (s1_last_r) begin
      priority if (pos_r < TOTAL_LAST_B) verdict_val = VERDICT_SHORT;
      else if (!magic_ok_nxt)            verdict_val = VERDICT_BAD_MAGIC;
      else if (!header_ok_nxt)           verdict_val = VERDICT_BAD_HEADER;
      else if (stored_nxt != ~crc_nxt)   verdict_val = VERDICT_BAD_CRC;
      else                               verdict_val = VERDICT_OK;
    end
  end

  // Clamp settings, play count and records; header, pad, CRC, extra bytes read zero.
  always_comb begin
    clean_val = 8'd0;
    is_fld    = 1'b0;
    priority if (pos_r >= OFS_DIFFICULTY && pos_r <= OFS_CLEARS) begin
      is_fld = 1'b1;
      unique case (pos_r)
        OFS_DIFFICULTY: clean_val = (v > 8'd2) ? 8'd1 : v;
        OFS_SHAKE:      clean_val = (v != 8'd0) ? 8'd1 : 8'd0;
        OFS_BRIGHTNESS: clean_val = (v > 8'd4) ? 8'd3 : v;
        OFS_FPS_FLAG:   clean_val = (v != 8'd0) ? 8'd1 : 8'd0;
        OFS_VSYNC:      clean_val = (v > 8'd2) ? 8'd0 : v;
        OFS_STAGE_CAP:  clean_val = (v < 8'd1 || v > 8'd5) ? 8'd1 : v;
        default:        clean_val = v;
      endcase
    end else if (pos_r >= OFS_PLAY_LO && pos_r <= OFS_PLAY_HI) begin
      is_fld    = 1'b1;
      clean_val = v;
    end else if (in_records) begin
      priority if (rec_r < REC_STAGE) begin
        is_fld    = 1'b1;
        clean_val = (v >= PRINT_LO && v < PRINT_HI) ? v : 8'd0;
      end else if (rec_r == REC_STAGE) begin
        is_fld    = 1'b1;
        clean_val = (v > 8'd6) ? 8'd1 : v;
      end else if (rec_r == REC_DIFF) begin
        is_fld    = 1'b1;
        clean_val = (v > 8'd2) ? 8'd1 : v;
      end else if (rec_r < REC_SCORE_END) begin
        is_fld    = 1'b1;
        clean_val = v;
      end else begin
        is_fld    = 1'b0;
      end
    end else begin
      is_fld = 1'b0;
    end
  end

  // Advance the offset and the position within a record; the final byte
  // returns everything to the start of a blob.
  always_comb begin
    pos_nxt = pos_r;
    rec_nxt = rec_r;
    if (s1_last_r) begin
      pos_nxt = 8'd0;
      rec_nxt = '0;
    end else begin
      if (pos_r != 8'hff) pos_nxt = pos_r + 8'd1;
      if (in_records) rec_nxt = (rec_r == REC_LAST) ? '0 : rec_r + REC_W'(1);
    end
  end

  // Input register: take a new request whenever it is free or draining.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      s1_data_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  // Blob tracking state, committed as each byte moves to the output.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= 8'd0;
      rec_r       <= '0;
      crc_r       <= CRC_INIT;
      stored_r    <= 32'd0;
      magic_ok_r  <= 1'b1;
      header_ok_r <= 1'b1;
    end else if (adv) begin
      pos_r <= pos_nxt;
      rec_r <= rec_nxt;
      if (s1_last_r) begin
        crc_r       <= CRC_INIT;
        stored_r    <= 32'd0;
        magic_ok_r  <= 1'b1;
        header_ok_r <= 1'b1;
      end else begin
        crc_r       <= crc_nxt;
        stored_r    <= stored_nxt;
        magic_ok_r  <= magic_ok_nxt;
        header_ok_r <= header_ok_nxt;
      end
    end
  end

  // Output register: hold until taken, reload on advance.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (adv) begin
      out_offset_r  <= pos_r;
      out_clean_r   <= clean_val;
      out_field_r   <= is_fld;
      out_done_r    <= s1_last_r;
      out_verdict_r <= verdict_val;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_verdict_r, out_clean_r, out_offset_r};
  assign out_tuser  = out_field_r;
  assign out_tlast  = out_done_r;

  // A result that does not close a blob always carries the ok code.
  `CCRS_ASSERT(a_verdict_only_on_done,
    (out_valid_r && !out_done_r) |-> (out_verdict_r == VERDICT_OK))

  // Field bytes only come from the settings block, the play count or the records.
  `CCRS_ASSERT(a_field_in_body,
    (out_valid_r && out_field_r) |-> (out_offset_r >= OFS_DIFFICULTY && out_offset_r < CRC_SPAN_B))

  // The final byte returns the tracker to the start of a blob.
  `CCRS_ASSERT_NEXT(a_restart_after_final, adv && s1_last_r,
    pos_r == 8'd0 && rec_r == '0 && crc_r == CRC_INIT && magic_ok_r && header_ok_r)

  // Any other byte moves the offset on by one until it saturates.
  `CCRS_ASSERT_NEXT(a_offset_steps, adv && !s1_last_r && pos_r != 8'hff,
    pos_r == $past(pos_r) + 8'd1)

endmodule
